### design/a2fb_pkg.sv
`default_nettype none

package a2fb_pkg;

   localparam logic [7:0]  CHAR_END    = 8'h00;
   localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
   localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
   localparam logic [7:0]  CHAR_X_LOW  = 8'h78;
   localparam logic [7:0]  CHAR_X_UP   = 8'h58;
   localparam logic [7:0]  EXP_BIAS    = 8'd127;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

   localparam logic [1:0]  POS_FIRST   = 2'd0;
   localparam logic [1:0]  POS_SECOND  = 2'd1;
   localparam logic [1:0]  POS_LATER   = 2'd2;

   localparam logic        STATUS_OK   = 1'b0;
   localparam logic        STATUS_ERR  = 1'b1;

   // parser state seen by the converter
   typedef struct packed {
      logic [31:0] accumulator;
      logic        hex_mode;
      logic        negative;
      logic        digit_seen;
      logic        format_error;
   } parse_state_type;

   // {valid, value}
   function automatic logic [4:0] dec_digit(input logic [7:0] c);
      logic [7:0] d;
      d = c - 8'h30;
      if (c >= 8'h30 && c <= 8'h39) begin
         dec_digit = {1'b1, d[3:0]};
      end else begin
         dec_digit = 5'd0;
      end
   endfunction

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] up;
      lo = c - 8'h57;
      up = c - 8'h37;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_digit = dec_digit(c);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         hex_digit = {1'b1, lo[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         hex_digit = {1'b1, up[3:0]};
      end else begin
         hex_digit = 5'd0;
      end
   endfunction

endpackage

`default_nettype wire

### design/a2fb_parser.sv
`default_nettype none

module a2fb_parser
   import a2fb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      character,
   output parse_state_type      state
);

   logic [31:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        hex_ff, hex_in;
   logic        zero_ff, zero_in;
   logic        neg_ff, neg_in;
   logic        seen_ff, seen_in;
   logic        err_ff, err_in;
   logic [4:0]  dd;
   logic [4:0]  hd;
   logic [31:0] acc_x10;

   assign dd      = dec_digit(character);
   assign hd      = hex_digit(character);
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      hex_in  = hex_ff;
      zero_in = zero_ff;
      neg_in  = neg_ff;
      seen_in = seen_ff;
      err_in  = err_ff;
      if (step) begin
         if (character == CHAR_END) begin
            acc_in  = '0;
            pos_in  = POS_FIRST;
            hex_in  = 1'b0;
            zero_in = 1'b0;
            neg_in  = 1'b0;
            seen_in = 1'b0;
            err_in  = 1'b0;
         end else begin
            if (!err_ff) begin
               if (pos_ff == POS_FIRST) begin
                  if (character == CHAR_MINUS) begin
                     neg_in = 1'b1;
                  end else if (character == CHAR_PLUS) begin
                     neg_in = neg_ff;
                  end else if (!dd[4]) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in  = {28'd0, dd[3:0]};
                     seen_in = 1'b1;
                     zero_in = (dd[3:0] == 4'd0);
                  end
               end else if (pos_ff == POS_SECOND && zero_ff &&
                            (character == CHAR_X_LOW || character == CHAR_X_UP)) begin
                  hex_in  = 1'b1;
                  seen_in = 1'b0;
                  acc_in  = '0;
               end else if (hex_ff) begin
                  if (!hd[4]) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in  = {acc_ff[27:0], hd[3:0]};
                     seen_in = 1'b1;
                  end
               end else begin
                  if (!dd[4]) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in  = acc_x10 + {28'd0, dd[3:0]};
                     seen_in = 1'b1;
                  end
               end
            end
            if (pos_ff != POS_LATER) begin
               pos_in = pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= POS_FIRST;
         hex_ff  <= 1'b0;
         zero_ff <= 1'b0;
         neg_ff  <= 1'b0;
         seen_ff <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         hex_ff  <= hex_in;
         zero_ff <= zero_in;
         neg_ff  <= neg_in;
         seen_ff <= seen_in;
         err_ff  <= err_in;
      end
   end

   assign state.accumulator  = acc_ff;
   assign state.hex_mode     = hex_ff;
   assign state.negative     = neg_ff;
   assign state.digit_seen   = seen_ff;
   assign state.format_error = err_ff;

endmodule

`default_nettype wire

### design/a2fb_convert.sv
`default_nettype none

module a2fb_convert
   import a2fb_pkg::*;
(
   input  parse_state_type      state,
   output logic [31:0]          value_bits,
   output logic                 status
);

   logic [4:0]  top;
   logic [31:0] norm;
   logic [31:0] fbits;
   logic [7:0]  expo;
   logic [4:0]  lshift;

   // leading one search; later (higher) bits win
   always_comb begin
      top = 5'd0;
      for (int k = 0; k < 32; k++) begin
         if (state.accumulator[k]) begin
            top = 5'(k);
         end
      end
   end

   assign lshift = 5'd31 - top;
   assign norm   = state.accumulator << lshift;
   assign expo   = {3'd0, top} + EXP_BIAS;

   always_comb begin
      if (state.accumulator == 32'd0) begin
         fbits = 32'd0;
      end else begin
         fbits = {state.negative, expo, norm[30:8]};
      end
   end

   always_comb begin
      if (!state.format_error && state.digit_seen) begin
         status     = STATUS_OK;
         value_bits = state.hex_mode ? state.accumulator : fbits;
      end else begin
         status     = STATUS_ERR;
         value_bits = 32'd0;
      end
   end

endmodule

`default_nettype wire

### design/ascii_number_to_float_bits.sv
`default_nettype none

// channel   ports                              direction  meaning
// req       req_valid/req_stall/req_character  in         one token byte per item, 0 ends
// rsp       rsp_valid/rsp_stall/...            out        value_bits and status per token
//
// One item a cycle sustained unless rsp_stall holds back an ending byte. A byte
// waits in the input register and the parser state updates as it leaves; an
// ending byte is converted from the parser state (leading-one search and shift)
// at that same edge, so its result is loaded into the result register as it leaves.
// Reset (synchronous) empties both registers and clears the parser state.
// rsp_stall only holds back an ending byte; other bytes keep flowing while a
// result waits, as they give no result.

module ascii_number_to_float_bits
   import a2fb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_character,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_value_bits,
   output logic             rsp_status
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            out_valid_ff, out_valid_in;
   logic [31:0]     out_bits_ff;
   logic            out_status_ff;
   logic            in_is_end;
   logic            out_free;
   logic            advance;
   logic            accept;
   logic            load_out;
   parse_state_type pstate;
   logic [31:0]     conv_bits;
   logic            conv_status;

   // ending byte needs room in the result register; others always advance
   assign in_is_end = (in_char_ff == CHAR_END);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_is_end || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign load_out  = advance && in_is_end;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);

   a2fb_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .character (in_char_ff),
      .state     (pstate)
   );

   a2fb_convert u_convert (
      .state      (pstate),
      .value_bits (conv_bits),
      .status     (conv_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_character;
      end
      if (load_out) begin
         out_bits_ff   <= conv_bits;
         out_status_ff <= conv_status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value_bits = out_bits_ff;
   assign rsp_status     = out_status_ff;

   // an error result carries no bits
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ERR |-> rsp_value_bits == 32'd0)
      else $error("error result with nonzero bits");

   // a result only appears after an ending byte left the input register
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff && in_is_end))
      else $error("result without ending byte");

   // input register only stalls when full with a blocked ending byte
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_is_end && out_valid_ff && rsp_stall)
      else $error("stall without cause");

   // a result waiting under stall is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !load_out)
      else $error("result overwritten");

endmodule

`default_nettype wire
